// ----- design/cao_pkg.sv -----
// Shared types, constants and helper functions of the cursor overlay blender.
package cao_pkg;

    // Cursor box size in pixels and cursor bitmap store geometry.
    localparam int CURSOR_W    = 32;
    localparam int CURSOR_H    = 32;
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COORD_W     = 12;
    localparam int PIXEL_W     = 32;
    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 16;

    // Configuration port geometry and register indexes.
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam logic [1:0] REG_CURSOR_LEFT  = 2'd0;
    localparam logic [1:0] REG_CURSOR_TOP   = 2'd1;
    localparam logic [1:0] REG_CURSOR_SHOWN = 2'd2;

    // Item operation codes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    // Alpha codes and the opaque alpha byte written by a partial blend.
    localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'h00;
    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // How the final stage forms its result.
    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_BLEND = 2'd1;

    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [PIXEL_W-1:0] t_pixel;

    // One input item.
    typedef struct packed {
        logic   op;
        t_coord pixel_col;
        t_coord pixel_row;
        t_pixel background;
        t_addr  bitmap_index;
        t_pixel bitmap_word;
    } t_in_item;

    // One result item.
    typedef struct packed {
        t_pixel pixel_out;
        logic   under_cursor;
    } t_out_item;

    // Configuration register contents.
    typedef struct packed {
        t_coord cursor_left;
        t_coord cursor_top;
        logic   cursor_shown;
    } t_cfg;

    // Pixel data handed from the lookup stage to the blend pipeline.
    typedef struct packed {
        logic   in_box;
        t_pixel background;
        t_pixel cursor;
    } t_blend_in;

    // Bitmap store address of a box offset, wrapping modulo the store depth.
    function automatic t_addr box_addr(input t_coord dx, input t_coord dy);
        logic [2*COORD_W-1:0] row_base;
        row_base = {{COORD_W{1'b0}}, dy} * (2*COORD_W)'(CURSOR_W);
        return ADDR_W'(row_base + {{COORD_W{1'b0}}, dx});
    endfunction

    // Exact division by 255 of a blend sum no larger than 255 * 255.
    function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] s);
        logic [SUM_W:0] t;
        t = {1'b0, s} + (SUM_W+1)'(1) + (SUM_W+1)'(s >> CHAN_W);
        return CHAN_W'(t >> CHAN_W);
    endfunction

endpackage

// ----- design/cursor_overlay_alpha_blend_top.sv -----
// Top level of the cursor overlay blender: box test, bitmap store and blend pipeline.
//
// Items arrive on the input channel (i_in_valid, o_in_stall, i_in_data). A load
// item writes one ARGB word into the 1024-word cursor store and gives no result.
// A pixel item gives one result on the output channel (o_out_valid, i_out_stall,
// o_out_data): the background, blended with the cursor word when the cursor is
// shown and the pixel lies inside the box.
// A pixel passes the lookup stage, the multiply stage and the output register.
// Throughput is one item per cycle unless the output stalls, set by the single
// read port of the cursor store, which is read once for every item that enters.
// A load followed at once by a pixel of the same entry sees the new word, since
// the write lands before the read.
// When the receiver stalls, the result holds in the output register and the two
// earlier stages keep filling; input is stalled only once all three are full.
// Reset clears the valid flags and the registers (position 0, cursor hidden). The
// store has no reset: only entries that have been loaded may be shown. The user
// writes position/show registers over APB only with no item in flight; unchecked.
module cursor_overlay_alpha_blend_top
    import cao_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg      cfg;
    logic      en1;
    logic      accept;
    logic      blend_stall;
    logic      in_box;
    t_coord    dx;
    t_coord    dy;
    t_addr     rd_addr;
    t_pixel    cursor_word;
    t_blend_in blend_in;

    // Lookup stage registers.
    logic      r_v1;
    logic      r_inside1;
    t_pixel    r_bg1;

    // Configuration registers.
    cao_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input transfer control.
    assign en1        = !r_v1 || !blend_stall;
    assign o_in_stall = !en1;
    assign accept     = i_in_valid && en1;

    // Cursor box test and bitmap store address.
    assign dx     = i_in_data.pixel_col - cfg.cursor_left;
    assign dy     = i_in_data.pixel_row - cfg.cursor_top;
    assign in_box = cfg.cursor_shown
                 && (i_in_data.pixel_col >= cfg.cursor_left)
                 && (i_in_data.pixel_row >= cfg.cursor_top)
                 && (dx < COORD_W'(CURSOR_W))
                 && (dy < COORD_W'(CURSOR_H));
    assign rd_addr = box_addr(dx, dy);

    // Cursor bitmap store: loads write, pixels read; read data holds on a stall.
    cao_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept && (i_in_data.op == OP_LOAD)),
        .i_waddr (i_in_data.bitmap_index),
        .i_wdata (i_in_data.bitmap_word),
        .i_re    (en1),
        .i_raddr (rd_addr),
        .o_rdata (cursor_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= accept && (i_in_data.op == OP_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_inside1 <= in_box;
            r_bg1     <= i_in_data.background;
        end
    end

    assign blend_in.in_box     = r_inside1;
    assign blend_in.background = r_bg1;
    assign blend_in.cursor     = cursor_word;

    // Blend pipeline and output register.
    cao_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_data  (blend_in),
        .o_stall (blend_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

// ----- design/cao_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module cao_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/cao_cfg.sv -----
// APB register file holding the cursor position and the show flag.
module cao_cfg
    import cao_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    // Register write decode; an address past the last register is ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_CURSOR_LEFT:  n_cfg.cursor_left  = pwdata[COORD_W-1:0];
                REG_CURSOR_TOP:   n_cfg.cursor_top   = pwdata[COORD_W-1:0];
                REG_CURSOR_SHOWN: n_cfg.cursor_shown = pwdata[0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read data mux.
    always_comb begin
        unique case (reg_idx)
            REG_CURSOR_LEFT:  prdata = APB_DATA_W'(r_cfg.cursor_left);
            REG_CURSOR_TOP:   prdata = APB_DATA_W'(r_cfg.cursor_top);
            REG_CURSOR_SHOWN: prdata = APB_DATA_W'(r_cfg.cursor_shown);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/cao_blend.sv -----
// Two-stage alpha blend pipeline ending in the output register.
module cao_blend
    import cao_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_blend_in i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall
);

    // Multiply stage registers.
    logic                 r_v2;
    logic [1:0]           r_mode2;
    logic                 r_inside2;
    t_pixel               r_pass2;
    logic [SUM_W-1:0]     r_sum2 [3];
    logic [1:0]           n_mode2;
    t_pixel               n_pass2;
    logic [SUM_W-1:0]     n_sum2 [3];

    // Output register.
    logic                 r_v3;
    t_out_item            r_out3;
    t_out_item            n_out3;

    logic                 en2;
    logic                 en3;
    logic [CHAN_W-1:0]    alpha;

    // Each stage moves on when it is empty or its successor moves on.
    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign o_stall = !en2;

    assign alpha = i_data.cursor[PIXEL_W-1 -: CHAN_W];

    // Alpha classification and the per-channel weighted sums.
    always_comb begin
        logic [CHAN_W-1:0] c;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] inv;
        inv = ALPHA_OPAQUE - alpha;
        for (int k = 0; k < 3; k++) begin
            c         = i_data.cursor[k*CHAN_W +: CHAN_W];
            b         = i_data.background[k*CHAN_W +: CHAN_W];
            n_sum2[k] = SUM_W'(c) * SUM_W'(alpha) + SUM_W'(b) * SUM_W'(inv);
        end
        n_mode2 = MODE_PASS;
        n_pass2 = i_data.background;
        if (i_data.in_box) begin
            if (alpha == ALPHA_OPAQUE) begin
                n_pass2 = i_data.cursor;
            end else if (alpha != ALPHA_CLEAR) begin
                n_mode2 = MODE_BLEND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_mode2   <= n_mode2;
            r_inside2 <= i_data.in_box;
            r_pass2   <= n_pass2;
            r_sum2    <= n_sum2;
        end
    end

    // Division by 255 and assembly of the result.
    always_comb begin
        n_out3.under_cursor = r_inside2;
        case (r_mode2)
            MODE_BLEND: n_out3.pixel_out = {ALPHA_OPAQUE, div255(r_sum2[2]),
                                            div255(r_sum2[1]), div255(r_sum2[0])};
            default:    n_out3.pixel_out = r_pass2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_out3 <= n_out3;
        end
    end

    assign o_valid = r_v3;
    assign o_data  = r_out3;

endmodule

// ----- design/cao_checker.sv -----
// Port-level checker of the cursor overlay blender and its bind to the top level.
module cao_checker
    import cao_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // Reset empties the output register.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // The input is stalled only while a result is offered and held by the receiver.
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

    // A stalled result stays offered.
    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result withdrawn under stall");

    // A stalled result does not change.
    a_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("result changed under stall");

endmodule

bind cursor_overlay_alpha_blend_top cao_checker u_cao_checker (.*);
